FILE: hdl/msc_pkg.sv
package msc_pkg;

  localparam int SENSOR_W   = 8;
  localparam int TIME_W     = 32;
  localparam int SCORE_W    = 16;
  localparam int WINDOW_W   = 20;
  localparam int MIN_W      = 7;
  localparam int COUNT_W    = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN    = 1'd1;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 20'd1000;
  localparam logic [MIN_W-1:0]    MIN_FLOOR    = 7'd2;

  localparam int MAX_RESULTS = 32;
  localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

  typedef struct packed {
    logic [SENSOR_W-1:0] sensor;
    logic [TIME_W-1:0]   time_ms;
    logic [SCORE_W-1:0]  score;
  } entry_t;

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_APPEND,
    OP_PURGE_RD,
    OP_PURGE_CHK,
    OP_GINIT,
    OP_IRD,
    OP_IGET,
    OP_BLK,
    OP_PLC_INIT,
    OP_PLC,
    OP_UPD,
    OP_CINIT,
    OP_CNT,
    OP_EINIT,
    OP_ERD,
    OP_EGET,
    OP_DIVT,
    OP_DIVS,
    OP_OUT,
    OP_LINIT,
    OP_LRD,
    OP_LGET,
    OP_LSCAN,
    OP_LSET,
    OP_KINIT,
    OP_KSCAN,
    OP_KEND
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic accept;
    logic expire;
    logic few;
    logic scan_done;
    logic last_i;
    logic emit_end;
    logic qual;
    logic div_done;
    logic out_free;
    logic no_results;
  } stat_t;

endpackage

FILE: hdl/msc_in_if.sv
interface msc_in_if import msc_pkg::*;;
  logic                valid;
  logic                ready;
  logic [SENSOR_W-1:0] sensor_id;
  logic [TIME_W-1:0]   event_time_ms;
  logic [SCORE_W-1:0]  event_score;
  logic [TIME_W-1:0]   now_ms;

  modport source (output valid, sensor_id, event_time_ms, event_score, now_ms, input ready);
  modport sink (input valid, sensor_id, event_time_ms, event_score, now_ms, output ready);
endinterface

FILE: hdl/msc_out_if.sv
interface msc_out_if import msc_pkg::*;;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] sensor_count;
  logic [TIME_W-1:0]  mean_time_ms;
  logic [SCORE_W-1:0] mean_score;
  logic               last;

  modport source (output valid, sensor_count, mean_time_ms, mean_score, last, input ready);
  modport sink (input valid, sensor_count, mean_time_ms, mean_score, last, output ready);
endinterface

FILE: hdl/msc_div.sv
module msc_div import msc_pkg::*; #(
  parameter int NW = 40,
  parameter int DW = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic [NW-1:0] quotient,
  output logic          done
);

  localparam int CNTW = $clog2(NW);

  logic [DW-1:0]   rem;
  logic [NW-1:0]   quo;
  logic [CNTW-1:0] cnt;
  logic            busy;
  logic [DW:0]     trial;

  assign trial    = {rem, quo[NW-1]};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo  <= dividend;
        rem  <= '0;
        cnt  <= CNTW'(NW - 1);
        busy <= 1'b1;
      end else if (busy) begin
        if (trial >= {1'b0, divisor}) begin
          rem <= DW'(trial - {1'b0, divisor});
          quo <= {quo[NW-2:0], 1'b1};
        end else begin
          rem <= trial[DW-1:0];
          quo <= {quo[NW-2:0], 1'b0};
        end
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule

FILE: hdl/msc_ctrl.sv
module msc_ctrl import msc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  stat_t st,
  output cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_APPEND, S_PRD, S_PCHK, S_GINIT, S_IRD, S_IGET, S_BLK, S_PLCI, S_PLC,
    S_UPD, S_CINIT, S_CNT, S_EINIT, S_ERD, S_EGET, S_DIVT, S_DIVS, S_OUT, S_LINIT,
    S_LRD, S_LGET, S_LSCAN, S_LSET, S_KINIT, S_KSCAN, S_KEND
  } state_t;

  state_t state, state_next;

  function automatic op_t op_of(state_t s);
    op_t o;
    case (s)
      S_IDLE:   o = OP_IDLE;
      S_APPEND: o = OP_APPEND;
      S_PRD:    o = OP_PURGE_RD;
      S_PCHK:   o = OP_PURGE_CHK;
      S_GINIT:  o = OP_GINIT;
      S_IRD:    o = OP_IRD;
      S_IGET:   o = OP_IGET;
      S_BLK:    o = OP_BLK;
      S_PLCI:   o = OP_PLC_INIT;
      S_PLC:    o = OP_PLC;
      S_UPD:    o = OP_UPD;
      S_CINIT:  o = OP_CINIT;
      S_CNT:    o = OP_CNT;
      S_EINIT:  o = OP_EINIT;
      S_ERD:    o = OP_ERD;
      S_EGET:   o = OP_EGET;
      S_DIVT:   o = OP_DIVT;
      S_DIVS:   o = OP_DIVS;
      S_OUT:    o = OP_OUT;
      S_LINIT:  o = OP_LINIT;
      S_LRD:    o = OP_LRD;
      S_LGET:   o = OP_LGET;
      S_LSCAN:  o = OP_LSCAN;
      S_LSET:   o = OP_LSET;
      S_KINIT:  o = OP_KINIT;
      S_KSCAN:  o = OP_KSCAN;
      S_KEND:   o = OP_KEND;
      default:  o = OP_IDLE;
    endcase
    return o;
  endfunction

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (st.accept) state_next = S_APPEND;
      S_APPEND: state_next = S_PRD;
      S_PRD:    state_next = S_PCHK;
      S_PCHK: begin
        if (st.expire) state_next = S_PRD;
        else if (st.few) state_next = S_KINIT;
        else state_next = S_GINIT;
      end
      S_GINIT:  state_next = S_IRD;
      S_IRD:    state_next = S_IGET;
      S_IGET:   state_next = S_BLK;
      S_BLK:    if (st.scan_done) state_next = S_PLCI;
      S_PLCI:   state_next = S_PLC;
      S_PLC:    if (st.scan_done) state_next = S_UPD;
      S_UPD:    state_next = st.last_i ? S_CINIT : S_IRD;
      S_CINIT:  state_next = S_CNT;
      S_CNT:    if (st.scan_done) state_next = S_EINIT;
      S_EINIT:  state_next = S_ERD;
      S_ERD: begin
        if (st.emit_end) state_next = st.no_results ? S_KINIT : S_LINIT;
        else state_next = S_EGET;
      end
      S_EGET:   state_next = st.qual ? S_DIVT : S_ERD;
      S_DIVT:   if (st.div_done) state_next = S_DIVS;
      S_DIVS:   if (st.div_done) state_next = S_OUT;
      S_OUT:    if (st.out_free) state_next = S_ERD;
      S_LINIT:  state_next = S_LRD;
      S_LRD:    state_next = S_LGET;
      S_LGET:   state_next = S_LSCAN;
      S_LSCAN:  if (st.scan_done) state_next = S_LSET;
      S_LSET:   state_next = st.last_i ? S_KINIT : S_LRD;
      S_KINIT:  state_next = S_KSCAN;
      S_KSCAN:  if (st.scan_done) state_next = S_KEND;
      S_KEND:   state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cmd.op <= OP_IDLE;
    end else begin
      state  <= state_next;
      cmd.op <= op_of(state_next);
    end
  end

endmodule

FILE: hdl/msc_dp.sv
module msc_dp import msc_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  msc_in_if.sink                in_ch,
  msc_out_if.source             out_ch,
  input  cmd_t                  cmd,
  output stat_t                 st
);

  localparam int CW  = $clog2(DEPTH + 1);
  localparam int IW  = $clog2(DEPTH);
  localparam int TW  = TIME_W + CW;
  localparam int SW  = SCORE_W + CW;
  localparam int MW0 = (CW > NRES_W) ? CW : NRES_W;
  localparam int MW  = (MW0 > MIN_W) ? MW0 : MIN_W;

  typedef struct packed {
    logic [TIME_W-1:0] first;
    logic [CW-1:0]     size;
    logic [TW-1:0]     tsum;
    logic [SW-1:0]     ssum;
  } grp_t;

  entry_t            emem [DEPTH+1];
  logic [IW-1:0]     lmem [DEPTH];
  grp_t              gmem [DEPTH];
  entry_t            rd_e;
  logic [IW-1:0]     rd_l;
  grp_t              rd_g;

  logic [WINDOW_W-1:0] window;
  logic [MIN_W-1:0]    min_s;
  entry_t              cur_in;
  logic [TIME_W-1:0]   now_in;
  entry_t              ent_i;
  logic [CW-1:0]       cnt, base, i, k, lim, pidx, ng, g, q, keep, ce, cb;
  logic                pv, found;
  logic [IW-1:0]       selg;
  grp_t                sel_rec, cur_rec;
  logic [NRES_W-1:0]   nres;
  logic [DEPTH-1:0]    blocked, emitted, leave;
  logic [TIME_W-1:0]   mean_t;
  logic [SCORE_W-1:0]  mean_s;

  logic                out_valid, out_last;
  logic [COUNT_W-1:0]  out_count;
  logic [TIME_W-1:0]   out_time;
  logic [SCORE_W-1:0]  out_score;

  logic [CW-1:0]       e_raddr, e_waddr;
  logic                e_we;
  entry_t              e_wdata;
  logic [IW-1:0]       g_raddr;

  logic                accept, scan_op, scan_issue, qual_rd, near, key_match, out_load;
  logic [WINDOW_W+1:0] max_age;
  logic [TIME_W-1:0]   age, tdiff;
  logic [NRES_W-1:0]   nres_inc;
  logic [MIN_W-1:0]    cfg_min;

  logic                div_start, div_done;
  logic [TW-1:0]       div_dividend, div_q;
  logic [CW-1:0]       div_divisor;

  assign accept     = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (cmd.op == OP_IDLE);

  assign scan_op    = (cmd.op == OP_BLK) || (cmd.op == OP_PLC) || (cmd.op == OP_CNT) ||
                      (cmd.op == OP_LSCAN) || (cmd.op == OP_KSCAN);
  assign scan_issue = (k < lim);

  assign max_age   = {2'b00, window} + {1'b0, window, 1'b0};
  assign age       = now_in - rd_e.time_ms;
  assign tdiff     = (ent_i.time_ms >= rd_g.first) ? (ent_i.time_ms - rd_g.first)
                                                   : (rd_g.first - ent_i.time_ms);
  assign near      = (tdiff <= TIME_W'(window));
  assign qual_rd   = (MW'(rd_g.size) >= MW'(min_s));
  assign key_match = (rd_e.sensor == ent_i.sensor) && (rd_e.time_ms == ent_i.time_ms);
  assign nres_inc  = nres + 1'b1;
  assign out_load  = (cmd.op == OP_OUT) && st.out_free;
  assign cfg_min   = (cfg_data[MIN_W-1:0] < MIN_FLOOR) ? MIN_FLOOR : cfg_data[MIN_W-1:0];

  assign st.accept     = accept;
  assign st.expire     = (cnt != '0) && (now_in > rd_e.time_ms) && (age > TIME_W'(max_age));
  assign st.few        = (MW'(cnt) < MW'(min_s));
  assign st.scan_done  = !scan_issue && !pv;
  assign st.last_i     = (({1'b0, i} + 1'b1) == {1'b0, cnt});
  assign st.emit_end   = (g == ng) || (MW'(nres) == MW'(q)) ||
                         (nres == NRES_W'(MAX_RESULTS));
  assign st.qual       = qual_rd;
  assign st.div_done   = div_done;
  assign st.out_free   = !out_valid || out_ch.ready;
  assign st.no_results = (nres == '0);

  always_comb begin
    e_raddr = CW'(base + k);
    case (cmd.op)
      OP_PURGE_RD:    e_raddr = base;
      OP_IRD, OP_LRD: e_raddr = CW'(base + i);
      default:        e_raddr = CW'(base + k);
    endcase
  end

  assign g_raddr = (cmd.op == OP_ERD) ? g[IW-1:0] : k[IW-1:0];

  always_comb begin
    e_we    = 1'b0;
    e_waddr = cnt;
    e_wdata = cur_in;
    case (cmd.op)
      OP_APPEND: e_we = 1'b1;
      OP_KSCAN: begin
        e_we    = pv && !leave[pidx[IW-1:0]];
        e_waddr = keep;
        e_wdata = rd_e;
      end
      default: e_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (e_we) emem[e_waddr] <= e_wdata;
    rd_e <= emem[e_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_UPD) lmem[i[IW-1:0]] <= found ? selg : ng[IW-1:0];
    rd_l <= lmem[k[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_UPD) begin
      if (found) begin
        gmem[selg] <= '{first: sel_rec.first,
                        size:  CW'(sel_rec.size + 1'b1),
                        tsum:  TW'(sel_rec.tsum + TW'(ent_i.time_ms)),
                        ssum:  SW'(sel_rec.ssum + SW'(ent_i.score))};
      end else begin
        gmem[ng[IW-1:0]] <= '{first: ent_i.time_ms,
                              size:  CW'(1),
                              tsum:  TW'(ent_i.time_ms),
                              ssum:  SW'(ent_i.score)};
      end
    end
    rd_g <= gmem[g_raddr];
  end

  assign div_start    = ((cmd.op == OP_EGET) && qual_rd) || ((cmd.op == OP_DIVT) && div_done);
  assign div_dividend = (cmd.op == OP_EGET) ? rd_g.tsum : TW'(cur_rec.ssum);
  assign div_divisor  = (cmd.op == OP_EGET) ? rd_g.size : cur_rec.size;

  msc_div #(.NW(TW), .DW(CW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_q),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= WINDOW_RESET;
      min_s  <= MIN_FLOOR;
      cnt    <= '0;
      base   <= '0;
      pv     <= 1'b0;
      k      <= '0;
      lim    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_WINDOW: window <= cfg_data[WINDOW_W-1:0];
          CFG_MIN:    min_s  <= cfg_min;
          default:    ;
        endcase
      end

      if (accept) begin
        cur_in <= '{sensor: in_ch.sensor_id, time_ms: in_ch.event_time_ms,
                    score: in_ch.event_score};
        now_in <= in_ch.now_ms;
      end

      if (scan_op) begin
        if (scan_issue) k <= k + 1'b1;
        pv   <= scan_issue;
        pidx <= k;
      end

      case (cmd.op)
        OP_APPEND: begin
          if (cnt == CW'(DEPTH)) base <= CW'(1);
          else cnt <= cnt + 1'b1;
          leave <= '0;
        end
        OP_PURGE_CHK: begin
          if (st.expire) begin
            base <= base + 1'b1;
            cnt  <= cnt - 1'b1;
          end
        end
        OP_GINIT: begin
          i  <= '0;
          ng <= '0;
        end
        OP_IGET: begin
          ent_i   <= rd_e;
          blocked <= '0;
          k       <= '0;
          pv      <= 1'b0;
          lim     <= i;
        end
        OP_BLK: begin
          if (pv && (rd_e.sensor == ent_i.sensor)) blocked[rd_l] <= 1'b1;
        end
        OP_PLC_INIT: begin
          k     <= '0;
          pv    <= 1'b0;
          lim   <= ng;
          found <= 1'b0;
        end
        OP_PLC: begin
          if (pv && !found && !blocked[pidx[IW-1:0]] && near) begin
            found   <= 1'b1;
            selg    <= pidx[IW-1:0];
            sel_rec <= rd_g;
          end
        end
        OP_UPD: begin
          i <= i + 1'b1;
          if (!found) ng <= ng + 1'b1;
        end
        OP_CINIT: begin
          k   <= '0;
          pv  <= 1'b0;
          lim <= ng;
          q   <= '0;
        end
        OP_CNT: begin
          if (pv && qual_rd) q <= q + 1'b1;
        end
        OP_EINIT: begin
          g       <= '0;
          nres    <= '0;
          emitted <= '0;
        end
        OP_EGET: begin
          cur_rec <= rd_g;
          g       <= g + 1'b1;
          if (qual_rd) emitted[g[IW-1:0]] <= 1'b1;
        end
        OP_DIVT: begin
          if (div_done) mean_t <= div_q[TIME_W-1:0];
        end
        OP_DIVS: begin
          if (div_done) mean_s <= div_q[SCORE_W-1:0];
        end
        OP_OUT: begin
          if (st.out_free) begin
            out_count <= COUNT_W'(cur_rec.size);
            out_time  <= mean_t;
            out_score <= mean_s;
            out_last  <= (MW'(nres_inc) == MW'(q)) || (nres_inc == NRES_W'(MAX_RESULTS));
            nres      <= nres_inc;
          end
        end
        OP_LINIT: i <= '0;
        OP_LGET: begin
          ent_i <= rd_e;
          k     <= '0;
          pv    <= 1'b0;
          lim   <= cnt;
          ce    <= '0;
          cb    <= '0;
        end
        OP_LSCAN: begin
          if (pv && key_match) begin
            if (emitted[rd_l]) ce <= ce + 1'b1;
            if (pidx < i) cb <= cb + 1'b1;
          end
        end
        OP_LSET: begin
          leave[i[IW-1:0]] <= (cb < ce);
          i <= i + 1'b1;
        end
        OP_KINIT: begin
          keep <= '0;
          k    <= '0;
          pv   <= 1'b0;
          lim  <= cnt;
        end
        OP_KSCAN: begin
          if (pv && !leave[pidx[IW-1:0]]) keep <= keep + 1'b1;
        end
        OP_KEND: begin
          cnt  <= keep;
          base <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.sensor_count = out_count;
  assign out_ch.mean_time_ms = out_time;
  assign out_ch.mean_score   = out_score;
  assign out_ch.last         = out_last;

endmodule

FILE: hdl/multi_sensor_coincidence_cluster_top.sv
// Coincidence clustering of sensor anomaly events.
// in_ch takes one event per transfer (sensor_id, event_time_ms, event_score, now_ms).
// out_ch gives zero to 32 correlated groups per event; last marks the final one.
// Configuration: cfg_we with cfg_index 0 sets window_ms, index 1 sets min_sensors
// (clamped to 2). Write only while the block is idle.
// One event at a time: in_ch.ready is high only when the previous event is done.
// The time an event takes grows with the number of pending entries and of reported
// groups; it is set by the entry scans of the grouping and removal passes over
// the entry memory, which has a single read port, and by the bit-serial divider
// (two divisions per group).
// First result appears after the grouping and counting passes and two divisions;
// each later result follows its own two divisions when the receiver is ready.
// A stalled receiver holds the output register and the block waits; the next
// event is accepted once the removal pass and compaction finish, even if the
// last result has not yet been taken.
// Reset empties the pending buffer and restores window_ms=1000, min_sensors=2.
module multi_sensor_coincidence_cluster_top import msc_pkg::*; #(
  parameter int PENDING_DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  msc_in_if.sink                in_ch,
  msc_out_if.source             out_ch
);

  cmd_t  cmd;
  stat_t st;

  msc_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  msc_dp #(.DEPTH(PENDING_DEPTH)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cmd       (cmd),
    .st        (st)
  );

  a_accept_append: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> (cmd.op == OP_APPEND))
    else $error("accepted event not appended");

  a_div_waited: assert property (@(posedge clk) disable iff (rst)
    st.div_done |-> ((cmd.op == OP_DIVT) || (cmd.op == OP_DIVS)))
    else $error("divider finished while not awaited");

  a_out_loaded: assert property (@(posedge clk) disable iff (rst)
    ((cmd.op == OP_OUT) && st.out_free) |=> out_ch.valid)
    else $error("result not presented after load");

endmodule
